// ===== hw/rtl/mdu_pkg.sv =====
`timescale 1ns / 1ps
package mdu_pkg;

  localparam int unsigned XLEN_DEF  = 64;
  localparam int unsigned OPERAND_W = 64;
  localparam int unsigned MODE_W    = 4;
  localparam int unsigned WORD_W    = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_MULH   = 4'd0,
    MODE_MULHSU = 4'd1,
    MODE_MULHU  = 4'd2,
    MODE_DIV    = 4'd3,
    MODE_DIVU   = 4'd4,
    MODE_DIVW   = 4'd5,
    MODE_DIVUW  = 4'd6,
    MODE_REM    = 4'd7,
    MODE_REMU   = 4'd8,
    MODE_REMW   = 4'd9,
    MODE_REMUW  = 4'd10
  } mode_e;

  typedef struct packed {
    logic is_mul;
    logic sa;
    logic sb;
  } mul_op_t;

  typedef struct packed {
    logic sgn;
    logic word;
    logic rem;
    logic zero;
  } div_op_t;

  // control carried down the divider stages
  typedef struct packed {
    logic neg_q;
    logic neg_r;
    logic word;
    logic rem;
    logic zero;
  } div_ctl_t;

  function automatic mul_op_t decode_mul(logic [MODE_W-1:0] m);
    mul_op_t o;
    o = '0;
    case (mode_e'(m))
      MODE_MULH:   o = '{is_mul: 1'b1, sa: 1'b1, sb: 1'b1};
      MODE_MULHSU: o = '{is_mul: 1'b1, sa: 1'b1, sb: 1'b0};
      MODE_MULHU:  o = '{is_mul: 1'b1, sa: 1'b0, sb: 1'b0};
      default:     o = '0;
    endcase
    return o;
  endfunction

  function automatic div_op_t decode_div(logic [MODE_W-1:0] m);
    div_op_t o;
    o = '0;
    case (mode_e'(m))
      MODE_DIV:   o = '{sgn: 1'b1, word: 1'b0, rem: 1'b0, zero: 1'b0};
      MODE_DIVU:  o = '{sgn: 1'b0, word: 1'b0, rem: 1'b0, zero: 1'b0};
      MODE_DIVW:  o = '{sgn: 1'b1, word: 1'b1, rem: 1'b0, zero: 1'b0};
      MODE_DIVUW: o = '{sgn: 1'b0, word: 1'b1, rem: 1'b0, zero: 1'b0};
      MODE_REM:   o = '{sgn: 1'b1, word: 1'b0, rem: 1'b1, zero: 1'b0};
      MODE_REMU:  o = '{sgn: 1'b0, word: 1'b0, rem: 1'b1, zero: 1'b0};
      MODE_REMW:  o = '{sgn: 1'b1, word: 1'b1, rem: 1'b1, zero: 1'b0};
      MODE_REMUW: o = '{sgn: 1'b0, word: 1'b1, rem: 1'b1, zero: 1'b0};
      default:    o = '{sgn: 1'b0, word: 1'b0, rem: 1'b0, zero: 1'b1};
    endcase
    return o;
  endfunction

endpackage

// ===== hw/rtl/mdu_req_if.sv =====
`timescale 1ns / 1ps
interface mdu_req_if;
  logic                               valid;
  logic                               ready;
  logic [mdu_pkg::MODE_W-1:0]         mode;
  logic [mdu_pkg::OPERAND_W-1:0]      operand_a;
  logic [mdu_pkg::OPERAND_W-1:0]      operand_b;

  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink (input valid, mode, operand_a, operand_b, output ready);
endinterface

// ===== hw/rtl/mdu_rsp_if.sv =====
`timescale 1ns / 1ps
interface mdu_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [mdu_pkg::OPERAND_W-1:0]      result_value;

  modport source (output valid, result_value, input ready);
  modport sink (input valid, result_value, output ready);
endinterface

// ===== hw/rtl/mdu_mul.sv =====
`timescale 1ns / 1ps
module mdu_mul #(
  parameter int unsigned XLEN = 64,
  parameter int unsigned LAT  = XLEN + 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic            sa_i,
  input  logic            sb_i,
  input  logic [XLEN-1:0] a_i,
  input  logic [XLEN-1:0] b_i,
  output logic            valid_o,
  output logic [XLEN-1:0] res_o
);
  localparam int unsigned H    = (XLEN + 1) / 2;
  localparam int unsigned HI_W = XLEN - H;
  localparam int unsigned PAD  = LAT - 3;

  logic [2*H-1:0]     p00_q;
  logic [XLEN-1:0]    p01_q, p10_q;
  logic [2*HI_W-1:0]  p11_q;
  logic [XLEN-1:0]    corr_d, corr_q, corr2_q;
  logic               v1_q, v2_q;
  logic [2*XLEN-1:0]  sum_d, sum_q;
  logic [XLEN-1:0]    dly_q [PAD+1];
  logic               dly_v_q [PAD+1];

  // signed operands: unsigned product, then subtract the other operand from the high half
  assign corr_d = ((sa_i && a_i[XLEN-1]) ? b_i : '0) + ((sb_i && b_i[XLEN-1]) ? a_i : '0);

  assign sum_d = {{(2*XLEN-2*H){1'b0}}, p00_q}
               + ({{XLEN{1'b0}}, p01_q} << H)
               + ({{XLEN{1'b0}}, p10_q} << H)
               + ({{(2*XLEN-2*HI_W){1'b0}}, p11_q} << (2*H));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      dly_v_q[0] <= 1'b0;
    end else if (en_i) begin
      v1_q       <= valid_i;
      v2_q       <= v1_q;
      dly_v_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q    <= (2*H)'(a_i[H-1:0]) * (2*H)'(b_i[H-1:0]);
      p01_q    <= XLEN'(a_i[H-1:0]) * XLEN'(b_i[XLEN-1:H]);
      p10_q    <= XLEN'(a_i[XLEN-1:H]) * XLEN'(b_i[H-1:0]);
      p11_q    <= (2*HI_W)'(a_i[XLEN-1:H]) * (2*HI_W)'(b_i[XLEN-1:H]);
      corr_q   <= corr_d;
      sum_q    <= sum_d;
      corr2_q  <= corr_q;
      dly_q[0] <= sum_q[2*XLEN-1:XLEN] - corr2_q;
    end
  end

  // delay line to line up with the divider latency
  for (genvar k = 1; k <= PAD; k++) begin : g_pad
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dly_v_q[k] <= 1'b0;
      end else if (en_i) begin
        dly_v_q[k] <= dly_v_q[k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dly_q[k] <= dly_q[k-1];
      end
    end
  end

  assign valid_o = dly_v_q[PAD];
  assign res_o   = dly_q[PAD];
endmodule

// ===== hw/rtl/mdu_div.sv =====
`timescale 1ns / 1ps
module mdu_div #(
  parameter int unsigned XLEN = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  mdu_pkg::div_op_t op_i,
  input  logic [XLEN-1:0]  a_i,
  input  logic [XLEN-1:0]  b_i,
  output logic             valid_o,
  output logic [XLEN-1:0]  res_o
);
  import mdu_pkg::*;

  localparam logic [XLEN-1:0] WORD_MASK = XLEN'({WORD_W{1'b1}});

  logic [XLEN-1:0] mask, aw, bw, ma, mb;
  logic            na, nb, dz;
  div_ctl_t        ctl_d;

  logic [XLEN-1:0] rem_q [XLEN+1];
  logic [XLEN-1:0] quo_q [XLEN+1];
  logic [XLEN-1:0] dvs_q [XLEN+1];
  div_ctl_t        ctl_q [XLEN+1];
  logic            v_q   [XLEN+1];

  logic [XLEN-1:0] qv, rv, sel;
  logic [XLEN-1:0] res_q;
  logic            out_v_q;

  always_comb begin
    mask = op_i.word ? WORD_MASK : '1;
    aw   = a_i & mask;
    bw   = b_i & mask;
    dz   = (bw == '0);
    // by zero: plain unsigned run gives all ones and the dividend
    na   = op_i.sgn && !dz && (op_i.word ? aw[WORD_W-1] : aw[XLEN-1]);
    nb   = op_i.sgn && !dz && (op_i.word ? bw[WORD_W-1] : bw[XLEN-1]);
    ma   = na ? ((-aw) & mask) : aw;
    mb   = nb ? ((-bw) & mask) : bw;
    ctl_d = '{neg_q: na ^ nb, neg_r: na, word: op_i.word, rem: op_i.rem, zero: op_i.zero};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      quo_q[0] <= ma;
      dvs_q[0] <= mb;
      ctl_q[0] <= ctl_d;
    end
  end

  // one restoring step per stage
  for (genvar k = 0; k < XLEN; k++) begin : g_step
    logic [XLEN:0] shifted, trial;
    logic          ge;

    assign shifted = {rem_q[k], quo_q[k][XLEN-1]};
    assign trial   = shifted - {1'b0, dvs_q[k]};
    assign ge      = !trial[XLEN];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? trial[XLEN-1:0] : shifted[XLEN-1:0];
        quo_q[k+1] <= {quo_q[k][XLEN-2:0], ge};
        dvs_q[k+1] <= dvs_q[k];
        ctl_q[k+1] <= ctl_q[k];
      end
    end
  end

  always_comb begin
    qv  = ctl_q[XLEN].neg_q ? -quo_q[XLEN] : quo_q[XLEN];
    rv  = ctl_q[XLEN].neg_r ? -rem_q[XLEN] : rem_q[XLEN];
    sel = ctl_q[XLEN].rem ? rv : qv;
    if (ctl_q[XLEN].word) begin
      sel = XLEN'(signed'(sel[WORD_W-1:0]));
    end
    if (ctl_q[XLEN].zero) begin
      sel = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= v_q[XLEN];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= sel;
    end
  end

  assign valid_o = out_v_q;
  assign res_o   = res_q;
endmodule

// ===== hw/rtl/rv64_mul_high_div_rem_unit.sv =====
`timescale 1ns / 1ps
// channel | dir | payload                          | handshake
// req_i   | in  | mode, operand_a, operand_b       | valid / ready
// rsp_o   | out | result_value                     | valid / ready
//
// the result passes through XLEN + 3 register stages from the accepting edge to rsp_o,
// one transaction accepted per cycle while rsp_o is not stalled
// the divider is one restoring step per stage, XLEN stages; the multiplier is
// padded to the same depth so results leave in order
// reset clears all valid bits; data registers are not reset
// a stall on rsp_o freezes the whole pipeline and drops req_i ready
module rv64_mul_high_div_rem_unit #(
  parameter int unsigned XLEN = mdu_pkg::XLEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mdu_req_if.sink     req_i,
  mdu_rsp_if.source   rsp_o
);
  import mdu_pkg::*;

  logic            en;
  mul_op_t         mop;
  div_op_t         dop;
  logic            mul_v, div_v;
  logic [XLEN-1:0] mul_r, div_r;
  logic            out_v_q;
  logic [XLEN-1:0] res_q;

  assign en          = !out_v_q || rsp_o.ready;
  assign req_i.ready = en;
  assign mop         = decode_mul(req_i.mode);
  assign dop         = decode_div(req_i.mode);

  mdu_mul #(.XLEN(XLEN), .LAT(XLEN + 2)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (req_i.valid && mop.is_mul),
    .sa_i    (mop.sa),
    .sb_i    (mop.sb),
    .a_i     (req_i.operand_a[XLEN-1:0]),
    .b_i     (req_i.operand_b[XLEN-1:0]),
    .valid_o (mul_v),
    .res_o   (mul_r)
  );

  mdu_div #(.XLEN(XLEN)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (req_i.valid && !mop.is_mul),
    .op_i    (dop),
    .a_i     (req_i.operand_a[XLEN-1:0]),
    .b_i     (req_i.operand_b[XLEN-1:0]),
    .valid_o (div_v),
    .res_o   (div_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= mul_v || div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= mul_v ? mul_r : div_r;
    end
  end

  assign rsp_o.valid        = out_v_q;
  assign rsp_o.result_value = OPERAND_W'(res_q);

`ifndef SYNTH
  a_one_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mul_v, div_v}))
    else $error("multiplier and divider finished together");

  a_hold_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(mul_v) && $stable(div_v))
    else $error("pipeline moved during a stall");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(mul_v || div_v))
    else $error("output valid without a finished transaction");
`endif
endmodule
